### sv/rnlp_pkg.sv
// Shared types, character codes and digit decode for the numeric literal parser.
// No dependencies; used by rnlp_lane, radix_numeric_literal_parser, literal_value_checker and testbench.
package rnlp_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  // Control for one accumulator lane
  typedef struct packed {
    logic step;   // fold the current character in
    logic clear;  // end of literal: back to zero
  } lane_ctrl_t;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;
  localparam logic [7:0] CH_LC_B    = 8'h62;
  localparam logic [7:0] CH_UC_B    = 8'h42;
  localparam logic [7:0] CH_LC_H    = 8'h68;
  localparam logic [7:0] CH_UC_H    = 8'h48;
  localparam logic [7:0] CH_LC_O    = 8'h6f;
  localparam logic [7:0] CH_UC_O    = 8'h4f;
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  // 0..15 for a hex digit of either case, DIGIT_NONE otherwise
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
    else if (c >= CH_LC_A && c <= CH_LC_F) d = 5'(c - CH_LC_A) + 5'd10;
    else if (c >= CH_UC_A && c <= CH_UC_F) d = 5'(c - CH_UC_A) + 5'd10;
    return d;
  endfunction

  function automatic logic [4:0] base_of(input radix_t r);
    logic [4:0] b;
    case (r)
      RADIX_HEX: b = 5'd16;
      RADIX_OCT: b = 5'd8;
      RADIX_BIN: b = 5'd2;
      RADIX_DEC: b = 5'd10;
      default:   b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

### sv/rnlp_lane.sv
// One accumulator lane: reads the literal in a fixed radix, with a sticky error bit.
// Depends on rnlp_pkg.
module rnlp_lane #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rnlp_pkg::radix_t       base,
  input  logic [7:0]             ch,
  input  rnlp_pkg::lane_ctrl_t   ctrl,
  output logic [VALUE_BITS-1:0]  acc,
  output logic [VALUE_BITS-1:0]  acc_next,
  output logic                   err,
  output logic                   err_next
);
  import rnlp_pkg::*;

  logic [4:0]            digit;
  logic                  bad;
  logic [VALUE_BITS-1:0] scaled;
  logic [VALUE_BITS-1:0] addend;

  always_comb begin
    digit = digit_of(ch);
    bad   = digit >= base_of(base);
    case (base)
      RADIX_HEX: scaled = acc << 4;
      RADIX_OCT: scaled = acc << 3;
      RADIX_BIN: scaled = acc << 1;
      RADIX_DEC: scaled = (acc << 3) + (acc << 1);
      default:   scaled = (acc << 3) + (acc << 1);
    endcase
    // an invalid character still shifts, but adds nothing
    addend   = bad ? '0 : VALUE_BITS'(digit);
    acc_next = scaled + addend;
    err_next = err | bad;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
      err <= 1'b0;
    end else if (ctrl.step) begin
      acc <= acc_next;
      err <= err_next;
    end
  end

endmodule

### sv/radix_numeric_literal_parser.sv
// Top level of the numeric literal parser: input register, six radix lanes, result register.
// Depends on rnlp_pkg and rnlp_lane.
//
// Usage:
//   Slave channel carries one ASCII character per item in s_tdata[7:0], first to
//   last; s_tlast marks the final character of a literal. Master channel gives
//   one item per literal: value, radix code and digit error flag.
//   Radix comes from the literal: 0x/0b prefix, h/o/B suffix, leading zero
//   (octal) or decimal. All readings run in parallel lanes and one is picked
//   on the final character.
//   Throughput: one character per cycle, including across literals, while the result slot can take a final character.
//   A final character passes from the input register into the result register,
//   which drives m_tvalid.
//   If the receiver stalls, the result register holds; characters that do not
//   end a literal keep flowing, and a final character waits in the input
//   register, with s_tready low, until the result slot frees.
//   Reset clears all lanes, the character position and both valid flags.
module radix_numeric_literal_parser #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] value, [33:32] radix, [34] digit_error, rest 0
);
  import rnlp_pkg::*;

  localparam int NUM_LANES = 6;
  // lanes 0..3 read every character; 4 and 5 skip the two prefix characters
  localparam int L_HEX = 0, L_OCT = 1, L_BIN = 2, L_DEC = 3, L_PHEX = 4, L_PBIN = 5;

  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;
  logic       advance;

  logic [1:0]  pos;
  logic [15:0] lead;

  lane_ctrl_t            ctrl_all;
  lane_ctrl_t            ctrl_pfx;
  radix_t                lane_base [NUM_LANES];
  logic [VALUE_BITS-1:0] lane_acc [NUM_LANES];
  logic [VALUE_BITS-1:0] lane_next [NUM_LANES];
  logic                  lane_err [NUM_LANES];
  logic                  lane_err_next [NUM_LANES];

  logic [7:0]            first_ch;
  logic [7:0]            second_ch;
  logic                  zero_lead;
  logic [VALUE_BITS-1:0] sel_value;
  radix_t                sel_radix;
  logic                  sel_bad;

  // advance the staged item unless it is a final one facing a full result slot that is not being read
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_comb begin
    ctrl_all.step  = advance && !in_last;
    ctrl_all.clear = advance && in_last;
    ctrl_pfx.step  = advance && !in_last && (pos == 2'd2);
    ctrl_pfx.clear = ctrl_all.clear;
  end

  assign lane_base[L_HEX]  = RADIX_HEX;
  assign lane_base[L_OCT]  = RADIX_OCT;
  assign lane_base[L_BIN]  = RADIX_BIN;
  assign lane_base[L_DEC]  = RADIX_DEC;
  assign lane_base[L_PHEX] = RADIX_HEX;
  assign lane_base[L_PBIN] = RADIX_BIN;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rnlp_lane #(
      .VALUE_BITS(VALUE_BITS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .base     (lane_base[i]),
      .ch       (in_ch),
      .ctrl     ((i >= L_PHEX) ? ctrl_pfx : ctrl_all),
      .acc      (lane_acc[i]),
      .acc_next (lane_next[i]),
      .err      (lane_err[i]),
      .err_next (lane_err_next[i])
    );
  end

  // remember the first two characters, saturate the position at two
  always_ff @(posedge clk) begin
    if (rst || ctrl_all.clear) begin
      pos  <= 2'd0;
      lead <= '0;
    end else if (ctrl_all.step) begin
      if (pos == 2'd0) lead[7:0]  <= in_ch;
      if (pos == 2'd1) lead[15:8] <= in_ch;
      if (pos != 2'd2) pos <= pos + 2'd1;
    end
  end

  always_comb begin
    first_ch  = (pos == 2'd0) ? in_ch : lead[7:0];
    second_ch = (pos == 2'd1) ? in_ch : lead[15:8];
    zero_lead = (first_ch == CH_ZERO) && (pos != 2'd0);
    sel_value = '0;
    sel_radix = RADIX_DEC;
    sel_bad   = 1'b0;
    if (zero_lead && (second_ch == CH_LC_X || second_ch == CH_UC_X)) begin
      sel_radix = RADIX_HEX;
      if (pos == 2'd2) begin
        sel_value = lane_next[L_PHEX];
        sel_bad   = lane_err_next[L_PHEX];
      end
    end else if (zero_lead && (second_ch == CH_LC_B || second_ch == CH_UC_B)) begin
      sel_radix = RADIX_BIN;
      if (pos == 2'd2) begin
        sel_value = lane_next[L_PBIN];
        sel_bad   = lane_err_next[L_PBIN];
      end
    end else if (in_ch == CH_LC_H || in_ch == CH_UC_H) begin
      sel_radix = RADIX_HEX;
      sel_value = lane_acc[L_HEX];
      sel_bad   = lane_err[L_HEX];
    end else if (in_ch == CH_LC_O || in_ch == CH_UC_O) begin
      sel_radix = RADIX_OCT;
      sel_value = lane_acc[L_OCT];
      sel_bad   = lane_err[L_OCT];
    end else if (in_ch == CH_UC_B) begin
      sel_radix = RADIX_BIN;
      sel_value = lane_acc[L_BIN];
      sel_bad   = lane_err[L_BIN];
    end else if (zero_lead) begin
      sel_radix = RADIX_OCT;
      sel_value = lane_next[L_OCT];
      sel_bad   = lane_err_next[L_OCT];
    end else begin
      sel_radix = RADIX_DEC;
      sel_value = lane_next[L_DEC];
      sel_bad   = lane_err_next[L_DEC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl_all.clear) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_all.clear) begin
      m_tdata <= {5'd0, sel_bad, sel_radix, 32'(sel_value)};
    end
  end

`ifndef SYNTH
  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    ctrl_all.clear |=> (pos == 2'd0))
    else $error("character position not cleared after final item");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos != 2'd3)
    else $error("character position out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !ctrl_all.clear)
    else $error("result register overwritten while stalled");

  a_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl_all.step && ctrl_all.clear))
    else $error("lane step and clear together");
`endif

endmodule

### dv/literal_value_checker.sv
`timescale 1ns / 1ps
// Checker for radix_numeric_literal_parser: follows accepted characters, predicts each
// literal's value, radix and digit error, and compares them with the result items.
// Depends on rnlp_pkg for the radix codes and character constants.
module literal_value_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [31:0] value, [33:32] radix, [34] digit_error
  output int          mismatches,
  output int          open_results,
  output int          results_seen
);
  import rnlp_pkg::*;

  localparam logic [4:0] BASE_HEX = 5'd16;
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_BIN = 5'd2;
  localparam logic [4:0] BASE_DEC = 5'd10;

  // Readings that run side by side; the tail lanes skip the first two characters
  typedef enum int {
    LANE_HEX, LANE_OCT, LANE_BIN, LANE_DEC, LANE_HEX_TAIL, LANE_BIN_TAIL
  } lane_e;
  localparam int NUM_LANES = 6;
  localparam logic [4:0] LANE_BASE [NUM_LANES] = '{
    BASE_HEX, BASE_OCT, BASE_BIN, BASE_DEC, BASE_HEX, BASE_BIN
  };

  typedef struct packed {
    logic [31:0] value;
    radix_t      radix;
    logic        bad;
  } literal_t;

  literal_t    expected_literals[$];
  logic [31:0] lane_acc [NUM_LANES];
  logic [NUM_LANES-1:0] lane_bad;
  logic [1:0]  seen;       // characters so far, saturating at 2
  logic [7:0]  first_ch;
  logic [7:0]  second_ch;
  int          miss_count;
  int          result_count;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c inside {[CH_ZERO:CH_NINE]}) return 5'(c - CH_ZERO);
    if (c inside {[CH_LC_A:CH_LC_F]}) return 5'(c - CH_LC_A + 8'd10);
    if (c inside {[CH_UC_A:CH_UC_F]}) return 5'(c - CH_UC_A + 8'd10);
    return DIGIT_NONE;
  endfunction

  // {miss, acc*base + digit}; a character that is no digit of the base adds zero, but the shift still happens
  function automatic logic [32:0] fold_digit(input logic [31:0] acc, input logic [4:0] base,
                                             input logic [7:0] c);
    logic [4:0] d;
    logic       miss;
    d = digit_value(c);
    miss = (d >= base);
    if (miss) d = '0;
    return {miss, acc * 32'(base) + 32'(d)};
  endfunction

  function automatic literal_t finish_literal(input logic [7:0] c);
    literal_t    r;
    logic [7:0]  lead0;
    logic [7:0]  lead1;
    logic        zero_lead;
    logic        hex;
    logic [32:0] f;
    int          lane;
    lead0 = (seen == 2'd0) ? c : first_ch;
    lead1 = (seen == 2'd1) ? c : second_ch;
    zero_lead = (lead0 == CH_ZERO) && (seen != 2'd0);
    r.value = '0;
    r.radix = RADIX_DEC;
    r.bad = 1'b0;
    if (zero_lead && (lead1 inside {CH_LC_X, CH_UC_X, CH_LC_B, CH_UC_B})) begin
      hex = (lead1 == CH_LC_X) || (lead1 == CH_UC_X);
      lane = hex ? LANE_HEX_TAIL : LANE_BIN_TAIL;
      r.radix = hex ? RADIX_HEX : RADIX_BIN;
      // a bare prefix has no digits at all
      if (seen == 2'd2) begin
        f = fold_digit(lane_acc[lane], LANE_BASE[lane], c);
        r.value = f[31:0];
        r.bad = lane_bad[lane] | f[32];
      end
    end else if (c == CH_LC_H || c == CH_UC_H) begin
      r.radix = RADIX_HEX;
      r.value = lane_acc[LANE_HEX];
      r.bad = lane_bad[LANE_HEX];
    end else if (c == CH_LC_O || c == CH_UC_O) begin
      r.radix = RADIX_OCT;
      r.value = lane_acc[LANE_OCT];
      r.bad = lane_bad[LANE_OCT];
    end else if (c == CH_UC_B) begin
      r.radix = RADIX_BIN;
      r.value = lane_acc[LANE_BIN];
      r.bad = lane_bad[LANE_BIN];
    end else if (zero_lead) begin
      f = fold_digit(lane_acc[LANE_OCT], BASE_OCT, c);
      r.radix = RADIX_OCT;
      r.value = f[31:0];
      r.bad = lane_bad[LANE_OCT] | f[32];
    end else begin
      f = fold_digit(lane_acc[LANE_DEC], BASE_DEC, c);
      r.value = f[31:0];
      r.bad = lane_bad[LANE_DEC] | f[32];
    end
    return r;
  endfunction

  task automatic clear_literal();
    foreach (lane_acc[i]) lane_acc[i] = '0;
    lane_bad = '0;
    seen = '0;
    first_ch = '0;
    second_ch = '0;
  endtask

  task automatic note_mismatch(input string msg);
    miss_count++;
    if (miss_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    literal_t    want;
    logic [32:0] f;
    if (rst) begin
      clear_literal();
      expected_literals.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (expected_literals.size() == 0) begin
          note_mismatch($sformatf("result %0d with nothing expected: value %h radix %0d error %0b",
                                  result_count, m_tdata[31:0], m_tdata[33:32], m_tdata[34]));
        end else begin
          want = expected_literals.pop_front();
          if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.radix ||
              m_tdata[34] !== want.bad)
            note_mismatch($sformatf(
              "result %0d: expected value %h radix %0d error %0b, got value %h radix %0d error %0b",
              result_count, want.value, want.radix, want.bad,
              m_tdata[31:0], m_tdata[33:32], m_tdata[34]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tlast) begin
          expected_literals.push_back(finish_literal(s_tdata));
          clear_literal();
        end else begin
          for (int i = 0; i < NUM_LANES; i++) begin
            if (i < LANE_HEX_TAIL || seen == 2'd2) begin
              f = fold_digit(lane_acc[i], LANE_BASE[i], s_tdata);
              lane_acc[i] = f[31:0];
              lane_bad[i] = lane_bad[i] | f[32];
            end
          end
          if (seen == 2'd0) first_ch = s_tdata;
          if (seen == 2'd1) second_ch = s_tdata;
          if (seen != 2'd2) seen = seen + 2'd1;
        end
      end
    end
    mismatches <= miss_count;
    open_results <= expected_literals.size();
    results_seen <= result_count;
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the literal parser testbench: clock, reset, character stimulus and result stalls.
// Depends on rnlp_pkg, radix_numeric_literal_parser and literal_value_checker.
module testbench;
  import rnlp_pkg::*;

  typedef logic [7:0] char_q_t[$];
  typedef enum int {
    FORM_HEX_PREFIX, FORM_BIN_PREFIX, FORM_HEX_SUFFIX, FORM_OCT_SUFFIX,
    FORM_BIN_SUFFIX, FORM_OCT_LEAD, FORM_DEC, FORM_NOISE
  } form_t;

  localparam int CHAR_TARGET = 725;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;

  int mismatches;
  int open_results;
  int results_seen;
  int chars_sent;
  int literals_sent;
  int rx_hold;
  bit tx_calm;
  bit rx_calm;

  radix_numeric_literal_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  literal_value_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .open_results(open_results), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_calm || $urandom_range(99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      rx_hold <= ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (tx_calm || r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  function automatic logic [7:0] rand_digit(input int base);
    int d;
    d = $urandom_range(base - 1);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(1) ? CH_LC_A : CH_UC_A) + 8'(d - 10);
  endfunction

  // Literal of the given form (random bytes for noise), now and then with one stray character
  function automatic char_q_t make_literal(input form_t form);
    char_q_t    q;
    int         n;
    int         base;
    logic [7:0] sfx;
    bit         all_f;
    n = ($urandom_range(15) == 0) ? $urandom_range(24, 9) : $urandom_range(6);
    sfx = '0;
    base = 0;
    case (form)
      FORM_HEX_PREFIX: begin
        q = {CH_ZERO, $urandom_range(1) ? CH_LC_X : CH_UC_X};
        base = 16;
      end
      FORM_BIN_PREFIX: begin
        q = {CH_ZERO, $urandom_range(1) ? CH_LC_B : CH_UC_B};
        base = 2;
      end
      FORM_HEX_SUFFIX: begin
        base = 16;
        sfx = $urandom_range(1) ? CH_LC_H : CH_UC_H;
      end
      FORM_OCT_SUFFIX: begin
        base = 8;
        sfx = $urandom_range(1) ? CH_LC_O : CH_UC_O;
      end
      FORM_BIN_SUFFIX: begin
        base = 2;
        sfx = CH_UC_B;
      end
      FORM_OCT_LEAD: begin
        q = {CH_ZERO};
        base = 8;
      end
      FORM_DEC: begin
        q = {CH_ZERO + 8'($urandom_range(9, 1))};
        base = 10;
      end
      default: base = 0;
    endcase
    if (base == 0) begin
      repeat (n + 1) q.push_back(8'($urandom_range(255)));
    end else begin
      all_f = (base == 16) && ($urandom_range(7) == 0);
      if (all_f) n = 8;
      for (int i = 0; i < n; i++) q.push_back(all_f ? CH_UC_F : rand_digit(base));
      if (sfx != '0) q.push_back(sfx);
    end
    if ($urandom_range(7) == 0)
      q[$urandom_range(q.size() - 1)] =
        $urandom_range(1) ? 8'($urandom_range(255)) : rand_digit(16);
    return q;
  endfunction

  // Valid stays high between characters unless a gap is drawn
  task automatic send_literal(input char_q_t chars);
    int gap;
    foreach (chars[i]) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= chars[i];
      s_tlast <= (i == chars.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      chars_sent++;
    end
    literals_sent++;
  endtask

  task automatic send_text(input string text);
    char_q_t q;
    for (int i = 0; i < text.len(); i++) q.push_back(text[i]);
    send_literal(q);
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open_results != 0);
  endtask

  initial begin
    char_q_t q;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // bare prefixes, lone suffixes, lone zero, bad digits, a high byte, then plain decimal and suffixed literals
    send_text("0x");
    send_text("0b");
    send_text("h");
    send_text("o");
    send_text("B");
    send_text("0");
    send_text("089");
    send_text("0xG");
    send_text("1AH");
    q = {8'hFF};
    send_literal(q);
    send_text("9");
    send_text("17O");
    send_text("10B");
    drain();

    while (chars_sent < CHAR_TARGET) begin
      if (literals_sent % 40 == 0) begin
        tx_calm = ($urandom_range(3) == 0);
        rx_calm = ($urandom_range(3) == 0);
      end
      if (literals_sent % 100 == 0) drain();
      send_literal(make_literal(form_t'($urandom_range(FORM_NOISE))));
    end
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d literals in %0d characters, %0d results checked: prefixed, suffixed,",
             literals_sent, chars_sent, results_seen);
    $display("leading-zero, decimal and noise literals with stray digits, wrap and stalls.");
    if (mismatches == 0 && open_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
